// ----- rtl/kpc_pkg.sv -----
// Shared types and constants for the key press classifier.
// Used by kpc_hold_key and key_press_classifier_core; depends on nothing else.
package kpc_pkg;

  localparam int CFG_W = 12;
  localparam int IDX_W = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_SHORT_MIN   = 3'd0,
    REG_LONG_MIN    = 3'd1,
    REG_LONG_MAX    = 3'd2,
    REG_STUCK_LIMIT = 3'd3,
    REG_SET_LONG    = 3'd4,
    REG_COMBO       = 3'd5,
    REG_IDLE_NOTICE = 3'd6
  } reg_idx_t;

  localparam logic [CFG_W-1:0] SHORT_MIN_RST   = 12'd10;
  localparam logic [CFG_W-1:0] LONG_MIN_RST    = 12'd60;
  localparam logic [CFG_W-1:0] LONG_MAX_RST    = 12'd1200;
  localparam logic [CFG_W-1:0] STUCK_LIMIT_RST = 12'd3000;
  localparam logic [CFG_W-1:0] SET_LONG_RST    = 12'd300;
  localparam logic [CFG_W-1:0] COMBO_RST       = 12'd300;
  localparam logic [CFG_W-1:0] IDLE_NOTICE_RST = 12'd1500;

  // Thresholds that every hold-counted key needs.
  typedef struct packed {
    logic [CFG_W-1:0] short_min;
    logic [CFG_W-1:0] long_min;
    logic [CFG_W-1:0] long_max;
    logic [CFG_W-1:0] stuck_limit;
  } hold_cfg_t;

  // What one hold-counted key reports for the current word.
  typedef struct packed {
    logic click;
    logic stuck_hit;
    logic hold;
  } hold_status_t;

endpackage

// ----- rtl/kpc_hold_key.sv -----
// Hold counter, hold flag and click detection for one of the up, clear, av keys.
// Depends on kpc_pkg for the threshold and status structs.
module kpc_hold_key #(
  parameter int COUNT_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 pressed,
  input  kpc_pkg::hold_cfg_t   cfg,
  output kpc_pkg::hold_status_t status
);

  localparam int CmpW = (COUNT_BITS > kpc_pkg::CFG_W) ? COUNT_BITS : kpc_pkg::CFG_W;
  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  logic [COUNT_BITS-1:0] count, count_next;
  logic                  flag, flag_next;
  logic [CmpW-1:0]       cnt_w, next_w;

  assign cnt_w  = CmpW'(count);
  assign next_w = CmpW'(count_next);

  always_comb begin
    count_next       = count;
    flag_next        = flag;
    status.click     = 1'b0;
    status.stuck_hit = 1'b0;
    if (pressed) begin
      if (cnt_w < CmpW'(cfg.stuck_limit)) begin
        count_next = (count == CntMax) ? count : count + 1'b1;
      end else begin
        count_next = COUNT_BITS'(cfg.stuck_limit);
      end
      flag_next = (next_w < CmpW'(cfg.long_max)) && (next_w > CmpW'(cfg.long_min));
    end else begin
      // A release that is neither a click nor at the limit keeps the flag.
      if ((cnt_w < CmpW'(cfg.long_min)) && (cnt_w > CmpW'(cfg.short_min))) begin
        status.click = 1'b1;
        flag_next    = 1'b0;
      end else if (cnt_w == CmpW'(cfg.stuck_limit)) begin
        status.stuck_hit = 1'b1;
        flag_next        = 1'b0;
      end
      count_next = '0;
    end
    status.hold = flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      flag  <= 1'b0;
    end else if (en) begin
      count <= count_next;
      flag  <= flag_next;
    end
  end

endmodule

// ----- rtl/key_press_classifier_core.sv -----
// Top level of the four-key press classifier: config registers, set-key logic,
// idle and busy counters and the result register. Uses kpc_pkg and kpc_hold_key.
//
// Usage: each input word is one scan tick with the pressed levels of the set,
// up, clear and av keys (1 = pressed), sent on in_valid / in_ready. Every word
// produces exactly one result word on out_valid / out_ready carrying click
// pulses, long set and combo events, the three hold flags, idle_notice,
// idle_long and stuck.
// The result of an accepted word is registered and shows from the
// next cycle. Throughput is one word per cycle while results are taken; the
// result register is the only stage, accepting a new word in the same cycle
// its result is taken, so in_ready follows out_ready while a result waits.
// When the receiver stalls, the result holds and in_ready drops until it is
// taken. Thresholds are written through cfg_we / cfg_index / cfg_data while
// no word is in flight; indexes beyond the last register are ignored.
// Synchronous reset loads the default thresholds, clears every counter and
// flag and empties the result register.
module key_press_classifier_core #(
  parameter int COUNT_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [kpc_pkg::IDX_W-1:0]     cfg_index,
  input  logic [kpc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          set_pressed,
  input  logic                          up_pressed,
  input  logic                          clear_pressed,
  input  logic                          av_pressed,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          set_click,
  output logic                          up_click,
  output logic                          clear_click,
  output logic                          av_click,
  output logic                          long_set_event,
  output logic                          combo_event,
  output logic                          up_hold,
  output logic                          clear_hold,
  output logic                          av_hold,
  output logic                          idle_notice,
  output logic                          idle_long,
  output logic                          stuck
);

  localparam int CmpW = (COUNT_BITS > kpc_pkg::CFG_W) ? COUNT_BITS : kpc_pkg::CFG_W;
  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  function automatic logic [COUNT_BITS-1:0] inc_sat(input logic [COUNT_BITS-1:0] v);
    return (v == CntMax) ? v : v + 1'b1;
  endfunction

  // Configuration registers.
  logic [kpc_pkg::CFG_W-1:0] short_min, long_min, long_max, stuck_limit;
  logic [kpc_pkg::CFG_W-1:0] set_long_ticks, combo_ticks, idle_notice_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_min         <= kpc_pkg::SHORT_MIN_RST;
      long_min          <= kpc_pkg::LONG_MIN_RST;
      long_max          <= kpc_pkg::LONG_MAX_RST;
      stuck_limit       <= kpc_pkg::STUCK_LIMIT_RST;
      set_long_ticks    <= kpc_pkg::SET_LONG_RST;
      combo_ticks       <= kpc_pkg::COMBO_RST;
      idle_notice_ticks <= kpc_pkg::IDLE_NOTICE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kpc_pkg::REG_SHORT_MIN:   short_min         <= cfg_data;
        kpc_pkg::REG_LONG_MIN:    long_min          <= cfg_data;
        kpc_pkg::REG_LONG_MAX:    long_max          <= cfg_data;
        kpc_pkg::REG_STUCK_LIMIT: stuck_limit       <= cfg_data;
        kpc_pkg::REG_SET_LONG:    set_long_ticks    <= cfg_data;
        kpc_pkg::REG_COMBO:       combo_ticks       <= cfg_data;
        kpc_pkg::REG_IDLE_NOTICE: idle_notice_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  logic accept;
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Hold-counted keys.
  kpc_pkg::hold_cfg_t    hold_cfg;
  kpc_pkg::hold_status_t up_st, clear_st, av_st;

  assign hold_cfg.short_min   = short_min;
  assign hold_cfg.long_min    = long_min;
  assign hold_cfg.long_max    = long_max;
  assign hold_cfg.stuck_limit = stuck_limit;

  kpc_hold_key #(.COUNT_BITS(COUNT_BITS)) u_up (
    .clk(clk), .rst(rst), .en(accept), .pressed(up_pressed), .cfg(hold_cfg), .status(up_st)
  );
  kpc_hold_key #(.COUNT_BITS(COUNT_BITS)) u_clear (
    .clk(clk), .rst(rst), .en(accept), .pressed(clear_pressed), .cfg(hold_cfg),
    .status(clear_st)
  );
  kpc_hold_key #(.COUNT_BITS(COUNT_BITS)) u_av (
    .clk(clk), .rst(rst), .en(accept), .pressed(av_pressed), .cfg(hold_cfg), .status(av_st)
  );

  // State.
  logic                  set_last_level, set_last_level_next;
  logic                  set_suppress, set_suppress_next;
  logic [COUNT_BITS-1:0] long_set_count, long_set_count_next;
  logic [COUNT_BITS-1:0] combo_count, combo_count_next;
  logic [COUNT_BITS-1:0] idle_count, idle_count_next;
  logic [COUNT_BITS-1:0] busy_count, busy_count_next;
  logic                  stuck_flag, stuck_flag_next;
  logic                  idle_long_flag, idle_long_flag_next;

  logic any_key, set_click_c, long_ev_c, combo_ev_c, notice_c, busy_sat;
  logic [CmpW-1:0] lim_w;

  assign any_key = set_pressed | up_pressed | clear_pressed | av_pressed;
  assign lim_w   = CmpW'(stuck_limit);

  always_comb begin
    set_click_c         = !set_pressed && set_last_level && !set_suppress;
    set_last_level_next = set_pressed;
    // A press edge clears suppression; a release keeps it.
    set_suppress_next   = (set_pressed && !set_last_level) ? 1'b0 : set_suppress;

    long_ev_c           = 1'b0;
    long_set_count_next = '0;
    if (set_pressed && !av_pressed && !up_pressed) begin
      if (CmpW'(long_set_count) >= CmpW'(set_long_ticks)) begin
        set_suppress_next = 1'b1;
        long_ev_c         = 1'b1;
      end else begin
        long_set_count_next = inc_sat(long_set_count);
      end
    end

    combo_ev_c       = 1'b0;
    combo_count_next = '0;
    if (av_pressed && set_pressed) begin
      if (CmpW'(combo_count) >= CmpW'(combo_ticks)) begin
        set_suppress_next = 1'b0;
        combo_ev_c        = 1'b1;
        combo_count_next  = combo_count;
      end else begin
        combo_count_next = inc_sat(combo_count);
      end
    end

    notice_c            = 1'b0;
    idle_count_next     = '0;
    idle_long_flag_next = 1'b0;
    if (!any_key) begin
      idle_long_flag_next = idle_long_flag;
      if (CmpW'(idle_count) < CmpW'(idle_notice_ticks)) begin
        idle_count_next = inc_sat(idle_count);
      end else begin
        notice_c = 1'b1;
        if (CmpW'(idle_count) < lim_w) begin
          idle_count_next = inc_sat(idle_count);
        end else begin
          idle_count_next     = COUNT_BITS'(stuck_limit);
          idle_long_flag_next = 1'b1;
        end
      end
    end

    busy_sat        = 1'b0;
    busy_count_next = '0;
    if (any_key) begin
      if (CmpW'(busy_count) < lim_w) begin
        busy_count_next = inc_sat(busy_count);
      end else begin
        busy_count_next = COUNT_BITS'(stuck_limit);
        busy_sat        = 1'b1;
      end
    end

    // Any tick with every key released clears stuck, even one that saw a
    // release at the limit.
    stuck_flag_next = any_key && (stuck_flag || busy_sat || up_st.stuck_hit ||
                                  clear_st.stuck_hit || av_st.stuck_hit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_last_level <= 1'b0;
      set_suppress   <= 1'b0;
      long_set_count <= '0;
      combo_count    <= '0;
      idle_count     <= '0;
      busy_count     <= '0;
      stuck_flag     <= 1'b0;
      idle_long_flag <= 1'b0;
    end else if (accept) begin
      set_last_level <= set_last_level_next;
      set_suppress   <= set_suppress_next;
      long_set_count <= long_set_count_next;
      combo_count    <= combo_count_next;
      idle_count     <= idle_count_next;
      busy_count     <= busy_count_next;
      stuck_flag     <= stuck_flag_next;
      idle_long_flag <= idle_long_flag_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_click      <= set_click_c;
      up_click       <= up_st.click;
      clear_click    <= clear_st.click;
      av_click       <= av_st.click;
      long_set_event <= long_ev_c;
      combo_event    <= combo_ev_c;
      up_hold        <= up_st.hold;
      clear_hold     <= clear_st.hold;
      av_hold        <= av_st.hold;
      idle_notice    <= notice_c;
      idle_long      <= idle_long_flag_next;
      stuck          <= stuck_flag_next;
    end
  end

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word produced no result");

  a_stuck_idle_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(stuck && idle_long))
    else $error("stuck and idle_long raised together");

  a_events_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(combo_event && long_set_event))
    else $error("combo and long set event in the same word");

  a_click_drops_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(up_click && up_hold) && !(clear_click && clear_hold) &&
                  !(av_click && av_hold))
    else $error("click reported with hold flag still set");

  a_notice_not_stuck: assert property (@(posedge clk) disable iff (rst)
    out_valid && idle_notice |-> !stuck)
    else $error("idle notice while stuck");

endmodule

// ----- dv/key_press_classifier_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for key_press_classifier_core: scan-tick words go in
// through a queue-fed driver, and a monitor compares every result word with a
// local prediction. Depends on kpc_pkg and the RTL of the classifier only.
module key_press_classifier_core_tb;

  localparam int CLK_HALF    = 5;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_STALL  = 60;
  localparam int NUM_REGS    = int'(kpc_pkg::REG_IDLE_NOTICE) + 1;
  localparam logic [kpc_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [kpc_pkg::CFG_W-1:0] CNT_SAT    = {kpc_pkg::CFG_W{1'b1}};

  typedef struct packed {
    logic set_p;
    logic up_p;
    logic clear_p;
    logic av_p;
  } keys_t;

  typedef struct packed {
    logic set_click;
    logic up_click;
    logic clear_click;
    logic av_click;
    logic long_set_event;
    logic combo_event;
    logic up_hold;
    logic clear_hold;
    logic av_hold;
    logic idle_notice;
    logic idle_long;
    logic stuck;
  } tick_result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_we = 1'b0;
  logic [kpc_pkg::IDX_W-1:0]   cfg_index = kpc_pkg::REG_SHORT_MIN;
  logic [kpc_pkg::CFG_W-1:0]   cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        set_pressed = 1'b0;
  logic                        up_pressed = 1'b0;
  logic                        clear_pressed = 1'b0;
  logic                        av_pressed = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        set_click, up_click, clear_click, av_click;
  logic                        long_set_event, combo_event;
  logic                        up_hold, clear_hold, av_hold;
  logic                        idle_notice, idle_long, stuck;

  key_press_classifier_core dut (.*);

  always #CLK_HALF clk = ~clk;

  keys_t        pending_ticks[$];
  tick_result_t expected_results[$];
  logic [kpc_pkg::CFG_W-1:0] cfg_next [NUM_REGS];

  int  mismatches = 0;
  int  results_seen = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  long_left = 0;
  int  quiet_cycles = 0;
  bit  idle_on = 1'b1;
  bit  long_hold_go = 1'b0;
  bit  long_hold_taken = 1'b0;

  // Local copy of the thresholds and of every counter and flag of the block.
  logic [kpc_pkg::CFG_W-1:0] thr [NUM_REGS];
  logic                      set_last, set_supp;
  logic [kpc_pkg::CFG_W-1:0] hold_cnt [3];
  logic                      hold_flag [3];
  logic [kpc_pkg::CFG_W-1:0] lone_set_cnt, combo_cnt, idle_cnt, busy_cnt;
  logic                      stuck_f, idle_long_f;

  function automatic logic [kpc_pkg::CFG_W-1:0] sat_inc(logic [kpc_pkg::CFG_W-1:0] v);
    return (v < CNT_SAT) ? v + 1'b1 : CNT_SAT;
  endfunction

  task automatic reset_predictor();
    thr[kpc_pkg::REG_SHORT_MIN]   = kpc_pkg::SHORT_MIN_RST;
    thr[kpc_pkg::REG_LONG_MIN]    = kpc_pkg::LONG_MIN_RST;
    thr[kpc_pkg::REG_LONG_MAX]    = kpc_pkg::LONG_MAX_RST;
    thr[kpc_pkg::REG_STUCK_LIMIT] = kpc_pkg::STUCK_LIMIT_RST;
    thr[kpc_pkg::REG_SET_LONG]    = kpc_pkg::SET_LONG_RST;
    thr[kpc_pkg::REG_COMBO]       = kpc_pkg::COMBO_RST;
    thr[kpc_pkg::REG_IDLE_NOTICE] = kpc_pkg::IDLE_NOTICE_RST;
    set_last = 1'b0;
    set_supp = 1'b0;
    for (int k = 0; k < 3; k++) begin
      hold_cnt[k]  = '0;
      hold_flag[k] = 1'b0;
    end
    lone_set_cnt = '0;
    combo_cnt    = '0;
    idle_cnt     = '0;
    busy_cnt     = '0;
    stuck_f      = 1'b0;
    idle_long_f  = 1'b0;
  endtask

  // Advances one hold-counted key; returns the click pulse.
  function automatic logic hold_step(int k, logic pressed);
    logic [kpc_pkg::CFG_W-1:0] c;
    logic [kpc_pkg::CFG_W-1:0] lim;
    logic                      click;
    c     = hold_cnt[k];
    lim   = thr[kpc_pkg::REG_STUCK_LIMIT];
    click = 1'b0;
    if (pressed) begin
      c = (c < lim) ? sat_inc(c) : lim;
      hold_flag[k] = (c < thr[kpc_pkg::REG_LONG_MAX]) && (c > thr[kpc_pkg::REG_LONG_MIN]);
    end else begin
      if ((c < thr[kpc_pkg::REG_LONG_MIN]) && (c > thr[kpc_pkg::REG_SHORT_MIN])) begin
        click = 1'b1;
        hold_flag[k] = 1'b0;
      end else if (c == lim) begin
        stuck_f = 1'b1;
        hold_flag[k] = 1'b0;
      end
      // A release that is neither a click nor at the limit keeps the flag.
      c = '0;
    end
    hold_cnt[k] = c;
    return click;
  endfunction

  function automatic tick_result_t classify_tick(keys_t k);
    tick_result_t              r;
    logic                      any;
    logic [kpc_pkg::CFG_W-1:0] lim;
    r   = '0;
    lim = thr[kpc_pkg::REG_STUCK_LIMIT];
    any = |k;

    if (!k.set_p && set_last && !set_supp) begin
      r.set_click = 1'b1;
    end else if (k.set_p != set_last) begin
      set_supp = set_last;
    end
    set_last = k.set_p;

    r.up_click    = hold_step(0, k.up_p);
    r.clear_click = hold_step(1, k.clear_p);
    r.av_click    = hold_step(2, k.av_p);

    // A lone set press ignores the clear key.
    if (k.set_p && !k.av_p && !k.up_p) begin
      if (lone_set_cnt >= thr[kpc_pkg::REG_SET_LONG]) begin
        set_supp = 1'b1;
        r.long_set_event = 1'b1;
        lone_set_cnt = '0;
      end else begin
        lone_set_cnt = sat_inc(lone_set_cnt);
      end
    end else begin
      lone_set_cnt = '0;
    end

    if (k.av_p && k.set_p) begin
      if (combo_cnt >= thr[kpc_pkg::REG_COMBO]) begin
        set_supp = 1'b0;
        r.combo_event = 1'b1;
      end else begin
        combo_cnt = sat_inc(combo_cnt);
      end
    end else begin
      combo_cnt = '0;
    end

    if (!any) begin
      if (idle_cnt < thr[kpc_pkg::REG_IDLE_NOTICE]) begin
        idle_cnt = sat_inc(idle_cnt);
      end else begin
        r.idle_notice = 1'b1;
        if (idle_cnt < lim) begin
          idle_cnt = sat_inc(idle_cnt);
        end else begin
          idle_cnt = lim;
          idle_long_f = 1'b1;
        end
      end
    end else begin
      idle_cnt = '0;
      idle_long_f = 1'b0;
    end

    if (any) begin
      if (busy_cnt < lim) begin
        busy_cnt = sat_inc(busy_cnt);
      end else begin
        busy_cnt = lim;
        stuck_f = 1'b1;
      end
    end else begin
      busy_cnt = '0;
      stuck_f = 1'b0;
    end

    r.up_hold    = hold_flag[0];
    r.clear_hold = hold_flag[1];
    r.av_hold    = hold_flag[2];
    r.idle_long  = idle_long_f;
    r.stuck      = stuck_f;
    return r;
  endfunction

  task automatic report_mismatch(tick_result_t want, tick_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("result %0d: clicks(s,u,c,a) exp %b got %b, long_set exp %b got %b",
               results_seen,
               {want.set_click, want.up_click, want.clear_click, want.av_click},
               {got.set_click, got.up_click, got.clear_click, got.av_click},
               want.long_set_event, got.long_set_event);
      $display("  combo exp %b got %b, holds(u,c,a) exp %b got %b",
               want.combo_event, got.combo_event,
               {want.up_hold, want.clear_hold, want.av_hold},
               {got.up_hold, got.clear_hold, got.av_hold});
      $display("  idle_notice exp %b got %b, idle_long exp %b got %b, stuck exp %b got %b",
               want.idle_notice, got.idle_notice, want.idle_long, got.idle_long,
               want.stuck, got.stuck);
    end
  endtask

  // Driver: offers the next word from the queue, with random gaps.
  always @(posedge clk) begin
    keys_t w;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_ticks.size() != 0) begin
        w = pending_ticks.pop_front();
        in_valid      <= 1'b1;
        set_pressed   <= w.set_p;
        up_pressed    <= w.up_p;
        clear_pressed <= w.clear_p;
        av_pressed    <= w.av_p;
        if (idle_on && $urandom_range(0, 11) == 0) gap_left <= $urandom_range(1, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: tracks config writes, checks results, predicts accepted words
  // and drives out_ready with random stalls and one long hold-off.
  always @(posedge clk) begin
    tick_result_t got;
    tick_result_t want;
    if (rst) begin
      reset_predictor();
      out_ready  <= 1'b0;
      stall_left <= 0;
      long_left  <= 0;
    end else begin
      if (cfg_we && cfg_index <= kpc_pkg::REG_IDLE_NOTICE) thr[cfg_index] = cfg_data;

      if (out_valid && out_ready) begin
        got = {set_click, up_click, clear_click, av_click, long_set_event, combo_event,
               up_hold, clear_hold, av_hold, idle_notice, idle_long, stuck};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d arrived with nothing expected", results_seen);
          end
        end else begin
          want = expected_results.pop_front();
          if (got !== want) report_mismatch(want, got);
        end
        results_seen++;
      end

      if (in_valid && in_ready) begin
        expected_results.push_back(classify_tick({set_pressed, up_pressed,
                                                  clear_pressed, av_pressed}));
      end

      if (long_left != 0) begin
        out_ready <= 1'b0;
        long_left <= long_left - 1;
      end else if (long_hold_go && !long_hold_taken) begin
        long_hold_taken <= 1'b1;
        long_left <= LONG_STALL;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        if (idle_on && $urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 9);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_run(keys_t k, int len);
    for (int i = 0; i < len; i++) pending_ticks.push_back(k);
  endtask

  function automatic keys_t pick_keys();
    case ($urandom_range(0, 9))
      0, 1, 2: return keys_t'(4'b0000);
      3:       return keys_t'(4'b1000);
      4:       return keys_t'(4'b0100);
      5:       return keys_t'(4'b0010);
      6:       return keys_t'(4'b0001);
      7:       return keys_t'(4'b1001);
      8:       return keys_t'(4'b1010);
      default: return keys_t'(4'($urandom_range(0, 15)));
    endcase
  endfunction

  // Mostly held levels of random length, so counters cross every threshold;
  // about one run in six is a single random tick.
  task automatic push_random(int n, int run_max);
    int count;
    int len;
    count = 0;
    while (count < n) begin
      if ($urandom_range(0, 5) == 0) begin
        pending_ticks.push_back(keys_t'(4'($urandom_range(0, 15))));
        count++;
      end else begin
        len = $urandom_range(1, run_max);
        push_run(pick_keys(), len);
        count += len;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic apply_cfg(bit with_unused);
    for (int i = 0; i < NUM_REGS; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= kpc_pkg::reg_idx_t'(i);
      cfg_data  <= cfg_next[i];
    end
    if (with_unused) begin
      @(posedge clk);
      cfg_index <= REG_UNUSED;
      cfg_data  <= kpc_pkg::CFG_W'($urandom);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int scale;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A couple of words at the reset thresholds.
    push_run(keys_t'(4'b1111), 1);
    push_run(keys_t'(4'b0000), 1);
    wait_drained();

    // Tiny thresholds so that every event shows up within a few words.
    cfg_next[kpc_pkg::REG_SHORT_MIN]   = 12'd0;
    cfg_next[kpc_pkg::REG_LONG_MIN]    = 12'd2;
    cfg_next[kpc_pkg::REG_LONG_MAX]    = 12'd4;
    cfg_next[kpc_pkg::REG_STUCK_LIMIT] = 12'd4;
    cfg_next[kpc_pkg::REG_SET_LONG]    = 12'd1;
    cfg_next[kpc_pkg::REG_COMBO]       = 12'd1;
    cfg_next[kpc_pkg::REG_IDLE_NOTICE] = 12'd1;
    apply_cfg(1'b0);
    push_run(keys_t'(4'b0000), 5);   // idle notice, then idle long
    push_run(keys_t'(4'b0100), 1);   // short up press ...
    push_run(keys_t'(4'b0000), 1);   // ... clicks on release
    push_run(keys_t'(4'b0010), 3);   // clear reaches its hold window
    push_run(keys_t'(4'b0000), 1);   // release outside click range keeps the flag
    push_run(keys_t'(4'b0001), 4);   // av up to the limit ...
    push_run(keys_t'(4'b0000), 1);   // ... hits the limit, but the all-released tick keeps stuck clear
    push_run(keys_t'(4'b1000), 1);
    push_run(keys_t'(4'b0000), 1);   // plain set click
    push_run(keys_t'(4'b1000), 2);   // long set event suppresses the click
    push_run(keys_t'(4'b0000), 1);
    push_run(keys_t'(4'b1001), 2);   // combo event lifts suppression
    push_run(keys_t'(4'b0000), 1);
    wait_drained();

    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin
          for (int i = 0; i < NUM_REGS; i++) cfg_next[i] = '0;
          cfg_next[kpc_pkg::REG_STUCK_LIMIT] = 12'd1;
          scale = 4;
        end
        1: begin
          for (int i = 0; i < NUM_REGS; i++) cfg_next[i] = CNT_SAT;
          scale = 40;
        end
        default: begin
          case (phase % 4)
            0:       scale = 6;
            1:       scale = 20;
            2:       scale = 60;
            default: scale = (phase == 7) ? 200 : 12;
          endcase
          for (int i = 0; i < NUM_REGS; i++) begin
            cfg_next[i] = kpc_pkg::CFG_W'($urandom_range(0, scale));
          end
          cfg_next[kpc_pkg::REG_STUCK_LIMIT] = kpc_pkg::CFG_W'($urandom_range(1, scale));
        end
      endcase
      apply_cfg(phase == 2);
      idle_on = !(phase == 4 || phase >= 8);
      if (phase == 3) long_hold_go = 1'b1;
      push_random(110, scale + scale / 2 + 2);
      wait_drained();
    end

    repeat (3) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
